@@ rtl/tsa_pkg.sv @@
// Shared constants for the tetrahedron surface area block.
package tsa_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 4;
  localparam int unsigned OutW         = 32;
  localparam int unsigned QueueDepth   = 4;

  // Edge vectors carried per item: d12, d13, d14, d23, d24.
  localparam int unsigned NumEdges     = 5;

endpackage

@@ rtl/tsa_queue.sv @@
// Small flop-based FIFO between the front and the back.
module tsa_queue import tsa_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/tsa_front.sv @@
// Front stage: accepts vertex beats and forms the edge vectors of all faces.
module tsa_front import tsa_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned DiffW     = CoordBits + 1,
  parameter int unsigned EdgeW     = NumEdges * 3 * DiffW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [CoordBits-1:0] p1_i [3],
  input  logic signed [CoordBits-1:0] p2_i [3],
  input  logic signed [CoordBits-1:0] p3_i [3],
  input  logic signed [CoordBits-1:0] p4_i [3],
  output logic                        q_wr_o,
  output logic [EdgeW-1:0]            q_wdata_o,
  input  logic                        q_full_i
);

  logic             valid_q;
  logic             load;
  logic [EdgeW-1:0] edges_d, edges_q;

  function automatic logic [DiffW-1:0] sub(logic signed [CoordBits-1:0] b,
                                           logic signed [CoordBits-1:0] a);
    logic signed [DiffW-1:0] r;
    r = {b[CoordBits-1], b} - {a[CoordBits-1], a};
    return r;
  endfunction

  // edge vectors d12, d13, d14, d23, d24, x/y/z each
  always_comb begin
    edges_d = '0;
    for (int k = 0; k < 3; k++) begin
      edges_d[(0*3+k)*DiffW +: DiffW] = sub(p2_i[k], p1_i[k]);
      edges_d[(1*3+k)*DiffW +: DiffW] = sub(p3_i[k], p1_i[k]);
      edges_d[(2*3+k)*DiffW +: DiffW] = sub(p4_i[k], p1_i[k]);
      edges_d[(3*3+k)*DiffW +: DiffW] = sub(p3_i[k], p2_i[k]);
      edges_d[(4*3+k)*DiffW +: DiffW] = sub(p4_i[k], p2_i[k]);
    end
  end

  assign q_wr_o    = valid_q;
  assign q_wdata_o = edges_q;
  assign full_o    = valid_q && q_full_i;
  assign load      = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !q_full_i) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      edges_q <= edges_d;
    end
  end

endmodule

@@ rtl/tsa_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module tsa_isqrt import tsa_pkg::*; #(
  parameter int unsigned RadW  = 64,
  parameter int unsigned RootW = RadW / 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [RadW-1:0]  rad_i,
  output logic [RootW-1:0] root_o
);

  logic [RadW-1:0]  rem_q  [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];

  // stage 0 holds the radicand
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
    end
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int unsigned Bit = RootW - 1 - s;
    logic [RadW-1:0] trial;
    logic            take;

    assign trial = (RadW'(root_q[s]) << (Bit + 1)) | (RadW'(1) << (2 * Bit));
    assign take  = (rem_q[s] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? rem_q[s] - trial : rem_q[s];
        root_q[s+1] <= take ? (root_q[s] | (RootW'(1) << Bit)) : root_q[s];
      end
    end
  end

  assign root_o = root_q[RootW];

endmodule

@@ rtl/tsa_face.sv @@
// One face: cross product, squared norm, scaling and floor root.
module tsa_face import tsa_pkg::*; #(
  parameter int unsigned DiffW = 13,
  parameter int unsigned FracBits = FracBitsDef,
  parameter int unsigned CrossW = 2 * DiffW + 1,
  parameter int unsigned RadW = 2 * CrossW + 2 + 2 * FracBits,
  parameter int unsigned RootW = RadW / 2
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [DiffW-1:0] u_i [3],
  input  logic signed [DiffW-1:0] v_i [3],
  output logic [RootW-1:0]        root_o
);

  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned SqW   = 2 * CrossW;
  localparam int unsigned NormW = SqW + 2;

  logic signed [ProdW-1:0]  prod_q  [6];
  logic signed [CrossW-1:0] cross_q [3];
  logic [SqW-1:0]           sq_q    [3];
  logic signed [SqW-1:0]    sq_full [3];
  logic [NormW-1:0]         norm;
  logic [RadW-1:0]          rad;

  // partial products of the cross product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q[0] <= u_i[1] * v_i[2];
      prod_q[1] <= u_i[2] * v_i[1];
      prod_q[2] <= u_i[2] * v_i[0];
      prod_q[3] <= u_i[0] * v_i[2];
      prod_q[4] <= u_i[0] * v_i[1];
      prod_q[5] <= u_i[1] * v_i[0];
    end
  end

  // cross product components
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cross_q[0] <= CrossW'(prod_q[0]) - CrossW'(prod_q[1]);
      cross_q[1] <= CrossW'(prod_q[2]) - CrossW'(prod_q[3]);
      cross_q[2] <= CrossW'(prod_q[4]) - CrossW'(prod_q[5]);
    end
  end

  // squares
  for (genvar k = 0; k < 3; k++) begin : g_sq
    assign sq_full[k] = cross_q[k] * cross_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= sq_full[k];
      end
    end
  end

  // squared norm scaled by the fraction bits
  assign norm = NormW'(sq_q[0]) + NormW'(sq_q[1]) + NormW'(sq_q[2]);
  assign rad  = RadW'(norm) << (2 * FracBits);

  tsa_isqrt #(
    .RadW  (RadW),
    .RootW (RootW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (rad),
    .root_o (root_o)
  );

endmodule

@@ rtl/tetrahedron_surface_area.sv @@
// Top level: twice the surface area of a tetrahedron, fixed point.
//
// Usage: vertex beats enter on the push/full side, one tetrahedron per beat;
// results leave on the empty/pop side, one beat per tetrahedron, in order.
// A beat is taken when push_i is high and full_o low; a result is taken when
// pop_i is high and empty_o low. twice_surface_o is twice the total area with
// FracBits fraction bits, each face root truncated before the sum.
// Throughput: one tetrahedron per cycle while results are popped.
// Path: the front register loads at the accepting edge; the item then passes
// the edge queue, the partial product, cross product and square registers, the
// root pipeline (one root bit per stage, RootW = 2*CoordBits+4+FracBits) and
// the output register.
// When the receiver stalls, the back pipeline freezes as a whole, the edge
// queue fills, and full_o rises once the front register also holds a beat.
// Reset clears all valid flags; no item is kept across reset.
module tetrahedron_surface_area import tsa_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef,
  parameter int unsigned FracBits  = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic signed [CoordBits-1:0] p1_x_i,
  input  logic signed [CoordBits-1:0] p1_y_i,
  input  logic signed [CoordBits-1:0] p1_z_i,
  input  logic signed [CoordBits-1:0] p2_x_i,
  input  logic signed [CoordBits-1:0] p2_y_i,
  input  logic signed [CoordBits-1:0] p2_z_i,
  input  logic signed [CoordBits-1:0] p3_x_i,
  input  logic signed [CoordBits-1:0] p3_y_i,
  input  logic signed [CoordBits-1:0] p3_z_i,
  input  logic signed [CoordBits-1:0] p4_x_i,
  input  logic signed [CoordBits-1:0] p4_y_i,
  input  logic signed [CoordBits-1:0] p4_z_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [OutW-1:0]             twice_surface_o
);

  localparam int unsigned DiffW  = CoordBits + 1;
  localparam int unsigned EdgeW  = NumEdges * 3 * DiffW;
  localparam int unsigned CrossW = 2 * DiffW + 1;
  localparam int unsigned RadW   = 2 * CrossW + 2 + 2 * FracBits;
  localparam int unsigned RootW  = RadW / 2;
  localparam int unsigned SumW   = RootW + 2;
  localparam int unsigned ExtW   = (SumW > OutW) ? SumW : OutW;
  localparam int unsigned Depth  = RootW + 4;

  logic signed [CoordBits-1:0] p1 [3], p2 [3], p3 [3], p4 [3];
  logic                        q_wr, q_full, q_empty;
  logic [EdgeW-1:0]            q_wdata, q_rdata;
  logic                        en;
  logic signed [DiffW-1:0]     edge_v [NumEdges][3];
  logic [RootW-1:0]            root [4];
  logic [Depth-1:0]            vld_q;
  logic                        out_valid_q;
  logic [OutW-1:0]             out_q;
  logic [ExtW-1:0]             sum;

  assign p1 = '{p1_x_i, p1_y_i, p1_z_i};
  assign p2 = '{p2_x_i, p2_y_i, p2_z_i};
  assign p3 = '{p3_x_i, p3_y_i, p3_z_i};
  assign p4 = '{p4_x_i, p4_y_i, p4_z_i};

  tsa_front #(
    .CoordBits (CoordBits),
    .DiffW     (DiffW),
    .EdgeW     (EdgeW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .p1_i      (p1),
    .p2_i      (p2),
    .p3_i      (p3),
    .p4_i      (p4),
    .q_wr_o    (q_wr),
    .q_wdata_o (q_wdata),
    .q_full_i  (q_full)
  );

  tsa_queue #(
    .Width (EdgeW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (en),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back pipeline moves as a whole whenever the output register can take a beat
  assign en = !out_valid_q || pop_i;

  for (genvar e = 0; e < NumEdges; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_comp
      assign edge_v[e][k] = q_rdata[(e*3+k)*DiffW +: DiffW];
    end
  end

  // faces (1,2,3), (1,2,4), (2,3,4), (1,3,4)
  tsa_face #(.DiffW(DiffW), .FracBits(FracBits), .CrossW(CrossW), .RadW(RadW),
             .RootW(RootW)) u_face_a (
    .clk_i (clk_i), .en_i (en), .u_i (edge_v[0]), .v_i (edge_v[1]), .root_o (root[0])
  );
  tsa_face #(.DiffW(DiffW), .FracBits(FracBits), .CrossW(CrossW), .RadW(RadW),
             .RootW(RootW)) u_face_b (
    .clk_i (clk_i), .en_i (en), .u_i (edge_v[0]), .v_i (edge_v[2]), .root_o (root[1])
  );
  tsa_face #(.DiffW(DiffW), .FracBits(FracBits), .CrossW(CrossW), .RadW(RadW),
             .RootW(RootW)) u_face_c (
    .clk_i (clk_i), .en_i (en), .u_i (edge_v[3]), .v_i (edge_v[4]), .root_o (root[2])
  );
  tsa_face #(.DiffW(DiffW), .FracBits(FracBits), .CrossW(CrossW), .RadW(RadW),
             .RootW(RootW)) u_face_d (
    .clk_i (clk_i), .en_i (en), .u_i (edge_v[1]), .v_i (edge_v[2]), .root_o (root[3])
  );

  // valid flags that travel with the back pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[Depth-2:0], !q_empty};
      out_valid_q <= vld_q[Depth-1];
    end
  end

  // sum of the face roots, saturated
  assign sum = ExtW'(root[0]) + ExtW'(root[1]) + ExtW'(root[2]) + ExtW'(root[3]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= (sum > ExtW'({OutW{1'b1}})) ? {OutW{1'b1}} : sum[OutW-1:0];
    end
  end

  assign empty_o         = !out_valid_q;
  assign twice_surface_o = out_q;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(out_q))
    else $error("result changed while stalled");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("back pipeline moved while frozen");

  a_full_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> q_full && q_wr)
    else $error("full raised without a waiting front beat");
`endif

endmodule

@@ bench/tb_tetrahedron_surface_area.sv @@
// Self-checking bench for the tetrahedron surface area block.
`timescale 1ns / 1ps

module tb_tetrahedron_surface_area;
  import tsa_pkg::*;

  localparam int CW = CoordBitsDef;
  localparam int FB = FracBitsDef;
  localparam int NRAND = 720;
  localparam int LATENCY = 60;
  localparam int IDLE_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t c[4][3];
  } tetra_t;

  // Predicts the doubled surface for each accepted beat, checks results in order.
  class surface_board;
    logic [OutW-1:0] area_q[$];
    int errors;
    int checked;

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned face_root(tetra_t t, int a, int b, int c);
      longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
      longint unsigned n2;
      ux = t.c[b][0] - t.c[a][0];
      uy = t.c[b][1] - t.c[a][1];
      uz = t.c[b][2] - t.c[a][2];
      vx = t.c[c][0] - t.c[a][0];
      vy = t.c[c][1] - t.c[a][1];
      vz = t.c[c][2] - t.c[a][2];
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      n2 = cx * cx + cy * cy + cz * cz;
      return root_floor(n2 << (2 * FB));
    endfunction

    function void note_tetra(tetra_t t);
      longint unsigned s;
      s = face_root(t, 0, 1, 2) + face_root(t, 0, 1, 3)
        + face_root(t, 1, 2, 3) + face_root(t, 0, 2, 3);
      if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      area_q.push_back(s[OutW-1:0]);
    endfunction

    function void check_area(logic [OutW-1:0] got);
      logic [OutW-1:0] exp_area;
      checked++;
      if (area_q.size() == 0) begin
        $error("twice_surface: unexpected result, actual %0d", got);
        errors++;
        return;
      end
      exp_area = area_q.pop_front();
      if (got !== exp_area) begin
        $error("twice_surface: expected %0d, actual %0d", exp_area, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  logic full_o, empty_o;
  logic [OutW-1:0] twice_surface_o;
  coord_t pc[4][3];

  surface_board board = new();
  int send_idle_pct = 7;
  int recv_idle_pct = 70;
  bit hold_recv = 1'b0;
  bit sending_done = 1'b0;
  int idle_cycles = 0;
  int sent = 0;

  always #2 clk_i = ~clk_i;

  tetrahedron_surface_area u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push_i), .full_o(full_o),
    .p1_x_i(pc[0][0]), .p1_y_i(pc[0][1]), .p1_z_i(pc[0][2]),
    .p2_x_i(pc[1][0]), .p2_y_i(pc[1][1]), .p2_z_i(pc[1][2]),
    .p3_x_i(pc[2][0]), .p3_y_i(pc[2][1]), .p3_z_i(pc[2][2]),
    .p4_x_i(pc[3][0]), .p4_y_i(pc[3][1]), .p4_z_i(pc[3][2]),
    .empty_o(empty_o), .pop_i(pop_i), .twice_surface_o(twice_surface_o)
  );

  initial begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++) pc[i][j] = '0;
  end

  // Sample both handshakes at the rising edge; watchdog on idle stretches.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tetra_t t;
      if (push_i && !full_o) begin
        t.c = pc;
        board.note_tetra(t);
        sent++;
      end
      if (pop_i && !empty_o) board.check_area(twice_surface_o);
      if ((push_i && !full_o) || (pop_i && !empty_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random pop at the falling edge, held low during a forced stall.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_recv) pop_i <= 1'b0;
    else pop_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one beat and hold it until accepted; push stays high for the next one.
  task automatic send_tetra(tetra_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    pc <= t.c;
    push_i <= 1'b1;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom());
    return coord_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic tetra_t rand_tetra();
    tetra_t t;
    int kind;
    int span;
    kind = $urandom_range(9);
    span = (kind < 4) ? 0 : (kind < 7 ? 15 : 300);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++) t.c[i][j] = rand_coord(span);
    // Some degenerate shapes: repeated or collinear vertices.
    if (kind == 9) begin
      t.c[3] = t.c[$urandom_range(2)];
    end else if (kind == 8) begin
      for (int j = 0; j < 3; j++)
        t.c[2][j] = t.c[0][j] + 2 * (t.c[1][j] - t.c[0][j]);
    end
    return t;
  endfunction

  task automatic wait_drained();
    while (board.area_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    tetra_t t;
    coord_t ext[4];
    ext = '{coord_t'(-2048), coord_t'(2047), coord_t'(0), coord_t'(-1)};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes, all-equal, unit shape, collinear and wide corners.
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++) t.c[i][j] = ext[k];
      send_tetra(t);
    end
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++)
          t.c[i][j] = ((i + j + k) % 2) ? coord_t'(2047) : coord_t'(-2048);
      t.c[k % 4][k % 3] = ext[k % 4];
      send_tetra(t);
    end
    t.c = '{'{0, 0, 0}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
    send_tetra(t);
    t.c = '{'{-2048, -2048, -2048}, '{2047, -2048, -2048},
            '{-2048, 2047, -2048}, '{-2048, -2048, 2047}};
    send_tetra(t);
    t.c = '{'{0, 0, 0}, '{1, 1, 1}, '{2, 2, 2}, '{5, -3, 7}};
    send_tetra(t);

    // Long receiver stall while beats keep coming, more than the block holds.
    hold_recv = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_recv = 1'b0;
      end
      for (int n = 0; n < 80; n++) send_tetra(rand_tetra());
    join
    push_i <= 1'b0;
    // Sender pause until every result is back.
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1 ? 70 : 0);
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1 ? 7 : 0);
      for (int n = 0; n < NRAND / 3; n++) send_tetra(rand_tetra());
    end
    push_i <= 1'b0;

    sending_done = 1'b1;
    wait_drained();
    repeat (LATENCY) @(negedge clk_i);
    $display("Sent %0d tetrahedra (extremes, degenerate faces, random spans)", sent);
    $display("Checked %0d results under backpressure and random gaps", board.checked);
    if (board.errors == 0 && board.area_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
